>>> src/cmdlex_pkg.sv
// Shared types, token codes and the keyword table for the command keyword lexer.
// No dependencies; compiled first.
package cmdlex_pkg;

    localparam int MAX_ATOM_LEN_DEF = 31;
    localparam int NUM_KEYWORDS     = 16;
    localparam int KW_MAX_CHARS     = 10;
    localparam int OUTQ_DEPTH       = 4;

    localparam logic [4:0] TOK_EOC     = 5'd0;
    localparam logic [4:0] TOK_UNKNOWN = 5'd1;

    localparam logic [7:0] CHAR_SEMI  = 8'h3B;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;

    // Strings are right-justified: first character sits in the highest used byte.
    localparam logic [KW_MAX_CHARS*8-1:0] KW_TEXT [NUM_KEYWORDS] = '{
        "set", "create", "draw", "title", "author", "creator", "page", "text",
        "image", "size", "angle", "pos", "dpi", "scale", "mask", "mask-image"
    };

    localparam logic [3:0] KW_LEN [NUM_KEYWORDS] = '{
        4'd3, 4'd6, 4'd4, 4'd5, 4'd6, 4'd7, 4'd4, 4'd4,
        4'd5, 4'd4, 4'd5, 4'd3, 4'd3, 4'd5, 4'd4, 4'd10
    };

    localparam logic [4:0] KW_CODE [NUM_KEYWORDS] = '{
        5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd6, 5'd7, 5'd8,
        5'd9, 5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd16
    };

    typedef struct packed {
        logic [4:0] token_code;
        logic       overflow;
        logic       last_of_run;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

    // Character at position pos of keyword k; caller guarantees pos < KW_LEN[k].
    function automatic logic [7:0] kw_byte(input logic [3:0] k, input logic [3:0] pos);
        logic [KW_MAX_CHARS*8-1:0] s;
        logic [3:0]                l;
        logic [6:0]                sh;
        s  = KW_TEXT[k];
        l  = KW_LEN[k];
        sh = {l - 4'd1 - pos, 3'b000};
        kw_byte = s[sh +: 8];
    endfunction

endpackage

>>> src/command_keyword_lexer_core.sv
// Command keyword lexer: one text byte per cycle in, keyword token codes out.
// Bytes pass an input register, then the atom state and a parallel compare against
// the 16 keywords, then a 4-entry result queue. Throughput is one byte per cycle;
// the byte is held back only while the queue has fewer than two free entries, which
// happens only when the consumer stalls; input then waits until the consumer drains
// the queue. A byte's results are written into the queue after the input register.
// Depends on cmdlex_pkg, cmdlex_scan and cmdlex_outq.
module command_keyword_lexer_core #(
    parameter int MAX_ATOM_LEN = cmdlex_pkg::MAX_ATOM_LEN_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] text_byte
    input  logic       s_tlast,   // end_of_input
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [4:0] token_code, [5] overflow, [7:6] zero
    output logic       m_tlast    // last_of_run
);
    import cmdlex_pkg::*;

    push_t   push;
    logic    room;
    result_t res;

    cmdlex_scan #(
        .MAX_ATOM_LEN(MAX_ATOM_LEN)
    ) u_scan (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_byte  (s_tdata),
        .in_eoi   (s_tlast),
        .room     (room),
        .push     (push)
    );

    cmdlex_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    assign m_tdata = {2'b00, res.overflow, res.token_code};
    assign m_tlast = res.last_of_run;

endmodule

>>> src/cmdlex_scan.sv
// Input register, atom state and keyword match for the command keyword lexer.
// Depends on cmdlex_pkg.
module cmdlex_scan #(
    parameter int MAX_ATOM_LEN = cmdlex_pkg::MAX_ATOM_LEN_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          in_byte,
    input  logic                in_eoi,
    input  logic                room,
    output cmdlex_pkg::push_t   push
);
    import cmdlex_pkg::*;

    localparam int ALW = $clog2(MAX_ATOM_LEN + 1);

    logic                    in_valid_reg, in_valid_next;
    logic [7:0]              in_byte_reg;
    logic                    in_eoi_reg;
    logic [NUM_KEYWORDS-1:0] mask_reg, mask_next;
    logic [ALW-1:0]          len_reg, len_next;
    logic                    ovf_reg, ovf_next;

    logic                    fire, is_term, is_ws, pending;
    logic [NUM_KEYWORDS-1:0] keep;
    logic [4:0]              tok;

    assign fire     = in_valid_reg && room;
    assign in_ready = !in_valid_reg || room;

    always_comb begin
        is_term = in_eoi_reg || (in_byte_reg == CHAR_SEMI);
        is_ws   = (in_byte_reg == CHAR_SPACE) || (in_byte_reg == CHAR_TAB) ||
                  (in_byte_reg == CHAR_CR) || (in_byte_reg == CHAR_LF);
        pending = (len_reg != '0);

        for (int k = 0; k < NUM_KEYWORDS; k++) begin
            keep[k] = (len_reg < ALW'(KW_LEN[k])) && (len_reg < ALW'(KW_MAX_CHARS)) &&
                      (kw_byte(4'(k), len_reg[3:0]) == in_byte_reg);
        end

        tok = TOK_UNKNOWN;
        for (int k = NUM_KEYWORDS - 1; k >= 0; k--) begin
            if (mask_reg[k] && (len_reg == ALW'(KW_LEN[k]))) begin
                tok = KW_CODE[k];
            end
        end
        if (ovf_reg) begin
            tok = TOK_UNKNOWN;
        end

        in_valid_next = in_ready ? in_valid : in_valid_reg;
        mask_next     = mask_reg;
        len_next      = len_reg;
        ovf_next      = ovf_reg;
        push          = '0;

        if (fire) begin
            if (is_term || is_ws) begin
                mask_next = '1;
                len_next  = '0;
                ovf_next  = 1'b0;
                if (is_term) begin
                    if (pending) begin
                        push.count  = 2'd2;
                        push.first  = '{token_code: tok, overflow: ovf_reg, last_of_run: 1'b0};
                        push.second = '{token_code: TOK_EOC, overflow: 1'b0, last_of_run: 1'b1};
                    end else begin
                        push.count = 2'd1;
                        push.first = '{token_code: TOK_EOC, overflow: 1'b0, last_of_run: 1'b1};
                    end
                end else if (pending) begin
                    push.count = 2'd1;
                    push.first = '{token_code: tok, overflow: ovf_reg, last_of_run: 1'b1};
                end
            end else if (len_reg >= ALW'(MAX_ATOM_LEN)) begin
                ovf_next = 1'b1;
            end else begin
                mask_next = mask_reg & keep;
                len_next  = len_reg + ALW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            mask_reg     <= '1;
            len_reg      <= '0;
            ovf_reg      <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            mask_reg     <= mask_next;
            len_reg      <= len_next;
            ovf_reg      <= ovf_next;
        end
        if (in_valid && in_ready) begin
            in_byte_reg <= in_byte;
            in_eoi_reg  <= in_eoi;
        end
    end

endmodule

>>> src/cmdlex_outq.sv
// Result queue for the command keyword lexer: takes up to two results per cycle.
// Depends on cmdlex_pkg.
module cmdlex_outq (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cmdlex_pkg::push_t     push,
    output logic                  room,
    output logic                  out_valid,
    input  logic                  out_ready,
    output cmdlex_pkg::result_t   out_res
);
    import cmdlex_pkg::*;

    localparam int PW = $clog2(OUTQ_DEPTH);
    localparam int CW = $clog2(OUTQ_DEPTH + 1);

    result_t       q_reg [OUTQ_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          pop;

    assign out_valid = (cnt_reg != '0);
    assign out_res   = q_reg[rd_ptr_reg];
    assign room      = (cnt_reg <= CW'(OUTQ_DEPTH - 2));
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + PW'(push.count);
        rd_ptr_next = rd_ptr_reg + PW'(pop);
        cnt_next    = cnt_reg + CW'(push.count) - CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
        if (push.count != 2'd0) begin
            q_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2) begin
            q_reg[wr_ptr_reg + PW'(1)] <= push.second;
        end
    end

endmodule

>>> src/cmdlex_checker.sv
// Port-level checks for the command keyword lexer, bound to the top level.
// Depends on cmdlex_pkg and command_keyword_lexer_core.
module cmdlex_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);
    import cmdlex_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    a_eoc_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[4:0] == TOK_EOC) |-> m_tlast && !m_tdata[5])
        else $error("end-of-command not last or flagged overflow");

    a_ovf_unknown: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[5] |-> (m_tdata[4:0] == TOK_UNKNOWN))
        else $error("overflowed atom with keyword code");

    a_nonlast_atom: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> (m_tdata[4:0] != TOK_EOC) && (m_tdata[7:6] == 2'b00))
        else $error("non-last result is not an atom token");

    a_code_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[4:0] <= 5'd16))
        else $error("token code out of range");

endmodule

bind command_keyword_lexer_core cmdlex_checker u_cmdlex_checker (.*);
